[src/serial_touch_erase_reset_sequencer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the serial touch-erase / reset sequencer
// Shared same-cycle-implication and next-cycle checks, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_TOUCH_ERASE_RESET_SEQUENCER_ASSERT_SVH
`define SERIAL_TOUCH_ERASE_RESET_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define STES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// next-cycle implication
`define STES_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

[src/stes_pkg.sv]
// ----------------------------------------------------------------------------
// stes_pkg
// Types and constants of the serial touch-erase / reset sequencer.
// ----------------------------------------------------------------------------
package stes_pkg;

  localparam int unsigned CNT_W      = 6;
  localparam int unsigned RATE_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_ACK        = 3'd1,
    ACT_TX_ALLOW   = 3'd2,
    ACT_SET_CTRL   = 3'd3,
    ACT_SET_CODING = 3'd4,
    ACT_OTHER      = 3'd5
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC_RATE  = 2'd0,
    CFG_ERASE_START = 2'd1,
    CFG_ERASE_END   = 2'd2,
    CFG_RESET_START = 2'd3
  } cfg_index_t;

  localparam logic [RATE_W-1:0] MAGIC_RATE_RST  = 32'd1200;
  localparam logic [CNT_W-1:0]  ERASE_START_RST = 6'd40;
  localparam logic [CNT_W-1:0]  ERASE_END_RST   = 6'd15;
  localparam logic [CNT_W-1:0]  RESET_START_RST = 6'd10;

  typedef struct packed {
    logic [2:0]        action;
    logic [7:0]        control_bits;
    logic [RATE_W-1:0] line_rate;
    logic [7:0]        char_format;
    logic [7:0]        parity_type;
    logic [7:0]        data_bits;
  } in_item_t;

  typedef struct packed {
    logic              erase_active;
    logic              reset_active;
    logic              send_ack;
    logic              go_transmit;
    logic              reconfigure_uart;
    logic [RATE_W-1:0] uart_rate;
    logic              clear_tx;
    logic              leds_off;
    logic              sequence_running;
  } out_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] magic_rate;
    logic [CNT_W-1:0]  erase_start_count;
    logic [CNT_W-1:0]  erase_end_count;
    logic [CNT_W-1:0]  reset_start_count;
  } cfg_regs_t;

endpackage

[src/stes_core.sv]
// ----------------------------------------------------------------------------
// stes_core
// Sequencer state and per-item update: line state, magic arming, countdown.
// ----------------------------------------------------------------------------
module stes_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  stes_pkg::in_item_t  item,
  input  stes_pkg::cfg_regs_t cfg,
  output stes_pkg::out_item_t result
);
  import stes_pkg::*;

  logic [CNT_W-1:0]  countdown_r, countdown_nxt;
  logic              timer_on_r, timer_on_nxt;
  logic              erase_pin_r, erase_pin_nxt;
  logic              reset_pin_r, reset_pin_nxt;
  logic              dtr_r, dtr_nxt;
  logic              armed_r, armed_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      countdown_r <= '0;
      timer_on_r  <= 1'b0;
      erase_pin_r <= 1'b0;
      reset_pin_r <= 1'b0;
      dtr_r       <= 1'b0;
      armed_r     <= 1'b0;
      rate_r      <= '0;
    end else if (step) begin
      countdown_r <= countdown_nxt;
      timer_on_r  <= timer_on_nxt;
      erase_pin_r <= erase_pin_nxt;
      reset_pin_r <= reset_pin_nxt;
      dtr_r       <= dtr_nxt;
      armed_r     <= armed_nxt;
      rate_r      <= rate_nxt;
    end
  end

  always_comb begin
    countdown_nxt = countdown_r;
    timer_on_nxt  = timer_on_r;
    erase_pin_nxt = erase_pin_r;
    reset_pin_nxt = reset_pin_r;
    dtr_nxt       = dtr_r;
    armed_nxt     = armed_r;
    rate_nxt      = rate_r;
    result        = '0;

    case (action_t'(item.action))
      ACT_TICK: begin
        if (timer_on_r) begin
          if (countdown_r != '0) begin
            if (countdown_r == cfg.erase_start_count) begin
              erase_pin_nxt = 1'b1;
              reset_pin_nxt = 1'b0;
            end
            if (countdown_r == cfg.erase_end_count) begin
              erase_pin_nxt = 1'b0;
              reset_pin_nxt = 1'b0;
            end
            if (countdown_r == cfg.reset_start_count) begin
              erase_pin_nxt = 1'b0;
              reset_pin_nxt = 1'b1;
            end
            if (countdown_r == CNT_W'(1)) begin
              erase_pin_nxt = 1'b0;
              reset_pin_nxt = 1'b0;
            end
            countdown_nxt = countdown_r - CNT_W'(1);
          end else begin
            erase_pin_nxt = 1'b0;
            reset_pin_nxt = 1'b0;
            timer_on_nxt  = 1'b0;
          end
        end
      end
      ACT_ACK: begin
        result.send_ack = 1'b1;
      end
      ACT_TX_ALLOW: begin
        result.go_transmit = 1'b1;
      end
      ACT_SET_CTRL: begin
        dtr_nxt = item.control_bits[0];
        if (armed_r) begin
          timer_on_nxt  = 1'b1;
          countdown_nxt = cfg.erase_start_count;
        end else if (!dtr_r && item.control_bits[0]) begin
          timer_on_nxt            = 1'b1;
          countdown_nxt           = cfg.reset_start_count;
          result.reconfigure_uart = 1'b1;
          result.clear_tx         = 1'b1;
        end
      end
      ACT_SET_CODING: begin
        rate_nxt                = item.line_rate;
        armed_nxt               = (item.line_rate == cfg.magic_rate);
        result.reconfigure_uart = 1'b1;
        result.leds_off         = 1'b1;
      end
      default: begin
      end
    endcase

    result.erase_active     = erase_pin_nxt;
    result.reset_active     = reset_pin_nxt;
    result.uart_rate        = rate_nxt;
    result.sequence_running = timer_on_nxt;
  end

`include "serial_touch_erase_reset_sequencer_assert.svh"

  `STES_ASSERT_IMP(a_pins_exclusive, clk, rst_n, erase_pin_r, !reset_pin_r)
  `STES_ASSERT_IMP(a_pin_needs_timer, clk, rst_n, erase_pin_r || reset_pin_r, timer_on_r)
  `STES_ASSERT_IMP(a_idle_count_zero, clk, rst_n, !timer_on_r, countdown_r == '0)
  `STES_ASSERT_NXT(a_hold_no_step, clk, rst_n, !step, $stable(countdown_r) && $stable(rate_r))

endmodule

[src/serial_touch_erase_reset_sequencer.sv]
// ----------------------------------------------------------------------------
// serial_touch_erase_reset_sequencer
// Serial-bridge command / tick sequencer for target erase and reset lines.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one decoded command or timer tick per item (valid/ready).
//   out_* : exactly one result item per input item, in order (valid/ready).
//   cfg_* : register writes (index, data), always ready; write only while
//           no item is in flight.
// Path: an accepted item is registered in the input register, then processed
//   and its result registered in the result register; out_valid rises when
//   that register is loaded.
// Throughput: one item per cycle; the input stage advances whenever the
//   result register is empty or being taken in the same cycle.
// Stall: if out_ready stays low, one item waits in the result register and
//   one in the input register; in_ready then drops until the result is taken.
// Reset (rst_n low, synchronous): pipeline emptied, lines released, timer
//   stopped, DTR and magic flag cleared, stored rate zero, registers back to
//   magic rate 1200 and counts 40, 15 and 10.
// ----------------------------------------------------------------------------
module serial_touch_erase_reset_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  stes_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output stes_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stes_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import stes_pkg::*;

  cfg_regs_t cfg_r;
  in_item_t  item_r;
  logic      item_valid_r;
  out_item_t out_r;
  logic      out_valid_r;
  out_item_t core_result;
  logic      advance;
  logic      step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_rate        <= MAGIC_RATE_RST;
      cfg_r.erase_start_count <= ERASE_START_RST;
      cfg_r.erase_end_count   <= ERASE_END_RST;
      cfg_r.reset_start_count <= RESET_START_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_MAGIC_RATE:  cfg_r.magic_rate        <= cfg_data[RATE_W-1:0];
        CFG_ERASE_START: cfg_r.erase_start_count <= cfg_data[CNT_W-1:0];
        CFG_ERASE_END:   cfg_r.erase_end_count   <= cfg_data[CNT_W-1:0];
        CFG_RESET_START: cfg_r.reset_start_count <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance  = !out_valid_r || out_ready;
  assign step     = item_valid_r && advance;
  assign in_ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= item_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (step) begin
      out_r <= core_result;
    end
  end

  stes_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .cfg    (cfg_r),
    .result (core_result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[bench/serial_touch_erase_reset_sequencer_check.sv]
// ----------------------------------------------------------------------------
// Sequencer result checker
// Watches the command, result and register channels of the sequencer, keeps
// its own copy of the countdown, line and DTR state, predicts one result per
// accepted item and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module serial_touch_erase_reset_sequencer_check (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  stes_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  stes_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [stes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stes_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              result_count,
  output int                              erase_starts,
  output int                              reset_starts,
  output int                              cfg_writes
);
  timeunit 1ns;
  timeprecision 1ps;

  import stes_pkg::*;

  cfg_regs_t         regs;
  logic [CNT_W-1:0]  count_left;
  logic              timer_run;
  logic              erase_line;
  logic              reset_line;
  logic              dtr_cur;
  logic              dtr_prev;
  logic              rts_cur;
  logic              rts_prev;
  logic              armed;
  logic [RATE_W-1:0] rate_held;
  logic [23:0]       format_held;
  out_item_t         due_results[$];
  out_item_t         want;
  string             diffs;

  function automatic out_item_t sequencer_response(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.action)
      ACT_TICK: begin
        if (timer_run) begin
          if (count_left != '0) begin
            if (count_left == regs.erase_start_count) begin
              erase_line = 1'b1;
              reset_line = 1'b0;
            end
            if (count_left == regs.erase_end_count) begin
              erase_line = 1'b0;
              reset_line = 1'b0;
            end
            if (count_left == regs.reset_start_count) begin
              erase_line = 1'b0;
              reset_line = 1'b1;
            end
            if (count_left == CNT_W'(1)) begin
              erase_line = 1'b0;
              reset_line = 1'b0;
            end
            count_left = count_left - 1'b1;
          end else begin
            erase_line = 1'b0;
            reset_line = 1'b0;
            timer_run  = 1'b0;
          end
        end
      end
      ACT_ACK:      r.send_ack = 1'b1;
      ACT_TX_ALLOW: r.go_transmit = 1'b1;
      ACT_SET_CTRL: begin
        dtr_prev = dtr_cur;
        rts_prev = rts_cur;
        dtr_cur  = it.control_bits[0];
        rts_cur  = it.control_bits[1];
        if (armed) begin
          timer_run  = 1'b1;
          count_left = regs.erase_start_count;
          erase_starts++;
        end else if (!dtr_prev && dtr_cur) begin
          timer_run  = 1'b1;
          count_left = regs.reset_start_count;
          reset_starts++;
          r.reconfigure_uart = 1'b1;
          r.clear_tx         = 1'b1;
        end
      end
      ACT_SET_CODING: begin
        rate_held   = it.line_rate;
        format_held = {it.data_bits, it.parity_type, it.char_format};
        armed       = (rate_held == regs.magic_rate);
        r.reconfigure_uart = 1'b1;
        r.leds_off         = 1'b1;
      end
      default: ;
    endcase
    r.erase_active     = erase_line;
    r.reset_active     = reset_line;
    r.uart_rate        = rate_held;
    r.sequence_running = timer_run;
    return r;
  endfunction

  function automatic string diff_fields(out_item_t w, out_item_t g);
    string s;
    s = "";
    if (g.erase_active !== w.erase_active) s = {s, " erase_active"};
    if (g.reset_active !== w.reset_active) s = {s, " reset_active"};
    if (g.send_ack !== w.send_ack) s = {s, " send_ack"};
    if (g.go_transmit !== w.go_transmit) s = {s, " go_transmit"};
    if (g.reconfigure_uart !== w.reconfigure_uart) s = {s, " reconfigure_uart"};
    if (g.uart_rate !== w.uart_rate) s = {s, " uart_rate"};
    if (g.clear_tx !== w.clear_tx) s = {s, " clear_tx"};
    if (g.leds_off !== w.leds_off) s = {s, " leds_off"};
    if (g.sequence_running !== w.sequence_running) s = {s, " sequence_running"};
    return s;
  endfunction

  function automatic string show(out_item_t r);
    return $sformatf("erase=%b reset=%b ack=%b tx=%b reconf=%b rate=%h clr=%b leds=%b run=%b",
                     r.erase_active, r.reset_active, r.send_ack, r.go_transmit,
                     r.reconfigure_uart, r.uart_rate, r.clear_tx, r.leds_off,
                     r.sequence_running);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.magic_rate        = MAGIC_RATE_RST;
      regs.erase_start_count = ERASE_START_RST;
      regs.erase_end_count   = ERASE_END_RST;
      regs.reset_start_count = RESET_START_RST;
      count_left   = '0;
      timer_run    = 1'b0;
      erase_line   = 1'b0;
      reset_line   = 1'b0;
      dtr_cur      = 1'b0;
      dtr_prev     = 1'b0;
      rts_cur      = 1'b0;
      rts_prev     = 1'b0;
      armed        = 1'b0;
      rate_held    = '0;
      format_held  = '0;
      fail_count   = 0;
      result_count = 0;
      erase_starts = 0;
      reset_starts = 0;
      cfg_writes   = 0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          CFG_MAGIC_RATE:  regs.magic_rate        = cfg_data;
          CFG_ERASE_START: regs.erase_start_count = cfg_data[CNT_W-1:0];
          CFG_ERASE_END:   regs.erase_end_count   = cfg_data[CNT_W-1:0];
          CFG_RESET_START: regs.reset_start_count = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) due_results.push_back(sequencer_response(in_data));
      if (out_valid && out_ready) begin
        result_count++;
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result, none outstanding: %s",
                                         show(out_data));
        end else begin
          want  = due_results.pop_front();
          diffs = diff_fields(want, out_data);
          if (diffs != "") begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch in result %0d:%s", result_count, diffs);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(out_data));
            end
          end
        end
      end
    end
    pending = due_results.size();
  end

endmodule

[bench/serial_touch_erase_reset_sequencer_test.sv]
// ----------------------------------------------------------------------------
// Sequencer testbench
// Drives commands and ticks into the sequencer through a directed opening
// and randomized erase / reset sequences under several register settings and
// sender / receiver throttling modes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module serial_touch_erase_reset_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stes_pkg::*;

  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam int         LIMIT      = 200000;
  localparam int         PHASE_ITEMS = 290;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_ready;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_ready;

  int fail_count;
  int pending;
  int result_count;
  int erase_starts;
  int reset_starts;
  int cfg_writes;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int items_sent = 0;
  int cycles     = 0;

  logic [RATE_W-1:0] cur_magic;
  logic [CNT_W-1:0]  cur_es;
  logic [CNT_W-1:0]  cur_rs;

  serial_touch_erase_reset_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  serial_touch_erase_reset_sequencer_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .erase_starts (erase_starts),
    .reset_starts (reset_starts),
    .cfg_writes   (cfg_writes)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic in_item_t rand_item(logic [2:0] act);
    in_item_t it;
    it.action       = act;
    it.control_bits = 8'($urandom);
    it.line_rate    = $urandom;
    it.char_format  = 8'($urandom);
    it.parity_type  = 8'($urandom);
    it.data_bits    = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t cmd(logic [2:0] act, logic [7:0] ctrl,
                                   logic [RATE_W-1:0] rate, logic [23:0] fmt);
    in_item_t it;
    it.action       = act;
    it.control_bits = ctrl;
    it.line_rate    = rate;
    it.char_format  = fmt[7:0];
    it.parity_type  = fmt[15:8];
    it.data_bits    = fmt[23:16];
    return it;
  endfunction

  task automatic push_item(in_item_t it);
    bit took;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    items_sent++;
  endtask

  task automatic ticks(int n);
    repeat (n) push_item(rand_item(ACT_TICK));
  endtask

  // wait until every item has come back out
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
  endtask

  // count registers get random upper bits, which the block must drop
  task automatic apply_setting(logic [RATE_W-1:0] magic, logic [CNT_W-1:0] es,
                               logic [CNT_W-1:0] ee, logic [CNT_W-1:0] rs);
    logic [CFG_DATA_W-1:0] val;
    drain();
    repeat (3) @(posedge clk);
    write_reg(CFG_MAGIC_RATE, magic);
    val = $urandom;
    val[CNT_W-1:0] = es;
    write_reg(CFG_ERASE_START, val);
    val = $urandom;
    val[CNT_W-1:0] = ee;
    write_reg(CFG_ERASE_END, val);
    val = $urandom;
    val[CNT_W-1:0] = rs;
    write_reg(CFG_RESET_START, val);
    cfg_valid <= 1'b0;
    cur_magic = magic;
    cur_es    = es;
    cur_rs    = rs;
  endtask

  // line coding, DTR edge, then ticks through the countdown with some noise
  task automatic play_sequence();
    in_item_t it;
    bit       hit;
    int       n;
    int       start;
    it = rand_item(ACT_SET_CODING);
    if ($urandom_range(1) == 1) it.line_rate = cur_magic;
    push_item(it);
    hit = (it.line_rate == cur_magic);
    if (!hit && $urandom_range(3) != 0) begin
      it = rand_item(ACT_SET_CTRL);
      it.control_bits[0] = 1'b0;
      push_item(it);
    end
    it = rand_item(ACT_SET_CTRL);
    if ($urandom_range(7) != 0) it.control_bits[0] = 1'b1;
    push_item(it);
    start = hit ? int'(cur_es) : int'(cur_rs);
    n = start + 1 + $urandom_range(2);
    if ($urandom_range(4) == 0) n = $urandom_range(start);
    repeat (n) begin
      if ($urandom_range(19) == 0) push_item(rand_item(3'($urandom_range(1, 7))));
      push_item(rand_item(ACT_TICK));
    end
  endtask

  task automatic run_phase(int idle, int stall, bit pause_mid);
    int target;
    int mid;
    bit paused;
    idle_pct  = idle;
    stall_pct = stall;
    target    = items_sent + PHASE_ITEMS;
    mid       = items_sent + PHASE_ITEMS / 2;
    paused    = 1'b0;
    while (items_sent < target) begin
      if (pause_mid && !paused && items_sent >= mid) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 70) play_sequence();
      else push_item(rand_item(3'($urandom_range(7))));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // erase start and end coincide; short reset count
    apply_setting(32'd1200, 6'd4, 6'd4, 6'd2);
    push_item(rand_item(ACT_TICK));
    push_item(rand_item(ACT_ACK));
    push_item(rand_item(ACT_TX_ALLOW));
    push_item(rand_item(ACT_OTHER));
    push_item(rand_item(ACT_SPARE6));
    push_item(rand_item(ACT_SPARE7));
    push_item(cmd(ACT_SET_CODING, 8'h00, 32'h0, 24'h000000));
    push_item(cmd(ACT_SET_CTRL, 8'h01, 32'h0, 24'h0));
    push_item(cmd(ACT_SET_CTRL, 8'h03, 32'h0, 24'h0));
    ticks(3);
    push_item(cmd(ACT_SET_CODING, 8'hFF, 32'd1200, 24'hC35AA5));
    push_item(cmd(ACT_SET_CTRL, 8'h00, 32'h0, 24'h0));
    push_item(cmd(ACT_SET_CTRL, 8'hFE, 32'h0, 24'h0));
    ticks(3);
    push_item(cmd(ACT_SET_CODING, 8'h00, 32'hFFFF_FFFF, 24'hFFFFFF));
    push_item(cmd(ACT_SET_CTRL, 8'h01, 32'h0, 24'h0));
    ticks(3);

    // start counts of zero
    apply_setting(32'hFFFF_FFFF, 6'd0, 6'd5, 6'd0);
    push_item(cmd(ACT_SET_CODING, 8'h00, 32'hFFFF_FFFF, 24'h123456));
    push_item(cmd(ACT_SET_CTRL, 8'h00, 32'h0, 24'h0));
    ticks(2);
    push_item(cmd(ACT_SET_CODING, 8'h00, 32'h0, 24'h0));
    push_item(cmd(ACT_SET_CTRL, 8'h01, 32'h0, 24'h0));
    ticks(1);

    apply_setting(32'd1200, 6'd40, 6'd15, 6'd10);
    run_phase(0, 0, 1'b0);
    apply_setting(32'h0, 6'd63, 6'd1, 6'd63);
    run_phase(61, 0, 1'b1);
    apply_setting(32'hFFFF_FFFF, 6'd1, 6'd63, 6'd1);
    run_phase(0, 61, 1'b1);
    apply_setting($urandom, 6'd12, 6'd6, 6'd6);
    run_phase(20, 20, 1'b0);
    apply_setting(32'd1200, 6'd9, 6'd9, 6'd3);
    run_phase(0, 0, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    $display("sent %0d items, checked %0d results in %0d cycles", items_sent, result_count,
             cycles);
    $display("%0d erase and %0d reset sequences started, %0d register writes, %0d failures",
             erase_starts, reset_starts, cfg_writes, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/stes_pkg.sv
src/stes_core.sv
src/serial_touch_erase_reset_sequencer.sv
bench/serial_touch_erase_reset_sequencer_check.sv
bench/serial_touch_erase_reset_sequencer_test.sv
